// ===== rtl/core/cjt_pkg.sv =====
// Shared types and constants for the contact joint table refresh block.
`default_nettype none

package cjt_pkg;

   localparam int FIELD_W      = 16;  // width of point and body fields on the ports
   localparam int PRIOR_W      = 7;   // signed prior slot field
   localparam int SLOT_FIELD_W = 6;   // joint_slot / live_count fields
   localparam int KIND_W       = 2;

   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SURV  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

   // table read address source
   typedef enum logic [1:0] {
      RD_REQ,    // prior slot straight off the request port
      RD_PRIOR,  // captured prior slot
      RD_LAST,   // last live entry
      RD_SCAN    // scan pointer
   } rd_sel_type;

   typedef struct packed {
      logic       capture;     // latch request fields
      logic       pt_commit;   // finish a point request, load ack
      logic       cmp_skip;    // scanned entry bound, advance
      logic       cmp_move;    // move last entry into scanned gap
      logic       emit_load;   // load survivor, advance
      logic       close_load;  // load closing item, clear marks
      logic       scan_clear;  // scan pointer back to 0
      rd_sel_type rd_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic req_mode;    // mode on the request port
      logic out_free;    // output register can take a result
      logic scan_done;   // scan pointer at or past live count
      logic scan_bound;  // bound mark of scanned entry
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/contact_joint_table_refresh.sv =====
// Top level: persistent contact joint table, refreshed once per frame.
//
//   channel  prefix  direction  handshake      payload
//   request  req_    in         valid / ready  mode, point, bodies, prior slot
//   result   rsp_    out        valid / ready  kind, slot, point, bodies, flags, count
//
// For a point request the table read is issued as the request is taken, and
// the result register loads in ST_POINT once the output register is free.
// End of frame scans the live entries in ST_SCAN, skipping bound ones and removing
// unbound ones through ST_MOVE, emits each survivor through ST_EMIT_RD and
// ST_EMIT_OUT, ends in ST_CLOSE; the table has a single shared read address.
// Reset (synchronous, active high) empties the table and clears all marks.
// A stalled result holds the sequencer; the next request is taken while the
// last result of the previous one still waits.
`default_nettype none

module contact_joint_table_refresh import cjt_pkg::*; #(
   parameter int JOINT_SLOTS = 32,
   parameter int INDEX_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_mode,
   input  wire logic [FIELD_W-1:0]        req_point_index,
   input  wire logic [FIELD_W-1:0]        req_body_a,
   input  wire logic [FIELD_W-1:0]        req_body_b,
   input  wire logic signed [PRIOR_W-1:0] req_prior_slot,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [KIND_W-1:0]              rsp_kind,
   output logic [SLOT_FIELD_W-1:0]        rsp_joint_slot,
   output logic [FIELD_W-1:0]             rsp_point_ref,
   output logic [FIELD_W-1:0]             rsp_joint_body_a_out,
   output logic [FIELD_W-1:0]             rsp_joint_body_b_out,
   output logic                           rsp_created,
   output logic                           rsp_overflow,
   output logic [SLOT_FIELD_W-1:0]        rsp_live_count,
   output logic                           rsp_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   cjt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cjt_dpath #(
      .JOINT_SLOTS (JOINT_SLOTS),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_mode             (req_mode),
      .req_point_index      (req_point_index),
      .req_body_a           (req_body_a),
      .req_body_b           (req_body_b),
      .req_prior_slot       (req_prior_slot),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_joint_slot       (rsp_joint_slot),
      .rsp_point_ref        (rsp_point_ref),
      .rsp_joint_body_a_out (rsp_joint_body_a_out),
      .rsp_joint_body_b_out (rsp_joint_body_b_out),
      .rsp_created          (rsp_created),
      .rsp_overflow         (rsp_overflow),
      .rsp_live_count       (rsp_live_count),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/cjt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cjt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cjt_dpath.sv =====
// Datapath: joint table storage, live count, scan pointer and result register.
`default_nettype none

module cjt_dpath import cjt_pkg::*; #(
   parameter int JOINT_SLOTS = 32,
   parameter int INDEX_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                cmd,
   output dp_status_type                  status,
   input  wire logic                      req_mode,
   input  wire logic [FIELD_W-1:0]        req_point_index,
   input  wire logic [FIELD_W-1:0]        req_body_a,
   input  wire logic [FIELD_W-1:0]        req_body_b,
   input  wire logic signed [PRIOR_W-1:0] req_prior_slot,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [KIND_W-1:0]              rsp_kind,
   output logic [SLOT_FIELD_W-1:0]        rsp_joint_slot,
   output logic [FIELD_W-1:0]             rsp_point_ref,
   output logic [FIELD_W-1:0]             rsp_joint_body_a_out,
   output logic [FIELD_W-1:0]             rsp_joint_body_b_out,
   output logic                           rsp_created,
   output logic                           rsp_overflow,
   output logic [SLOT_FIELD_W-1:0]        rsp_live_count,
   output logic                           rsp_last
);

   localparam int SW = $clog2(JOINT_SLOTS);
   localparam int CW = $clog2(JOINT_SLOTS + 1);
   localparam int IW = INDEX_WIDTH;

   // captured request
   logic [IW-1:0]      point_ff, body_a_ff, body_b_ff;
   logic [PRIOR_W-1:0] prior_ff;

   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic [JOINT_SLOTS-1:0] bound_ff, bound_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [SLOT_FIELD_W-1:0] slot_ff, slot_in;
   logic [FIELD_W-1:0]      pref_ff, pref_in;
   logic [FIELD_W-1:0]      oba_ff, oba_in;
   logic [FIELD_W-1:0]      obb_ff, obb_in;
   logic                    created_ff, created_in;
   logic                    overflow_ff, overflow_in;
   logic [SLOT_FIELD_W-1:0] live_ff, live_in;
   logic                    last_ff, last_in;

   // table ports
   logic [SW-1:0]   rd_addr;
   logic            body_we, point_we;
   logic [SW-1:0]   body_waddr, point_waddr;
   logic [2*IW-1:0] body_wdata, body_rdata;
   logic [IW-1:0]   point_wdata, point_rdata;

   logic [SW-1:0] scan_idx, last_idx, count_idx, prior_idx;
   logic          out_free, prior_ok, full, rebind, append, ovf;

   assign scan_idx  = scan_ff[SW-1:0];
   assign count_idx = count_ff[SW-1:0];
   assign last_idx  = SW'(count_ff - CW'(1));
   assign prior_idx = SW'(prior_ff[SLOT_FIELD_W-1:0]);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign prior_ok = !prior_ff[PRIOR_W-1] &&
                     (PRIOR_W'(prior_ff[SLOT_FIELD_W-1:0]) < PRIOR_W'(count_ff));
   assign full     = count_ff >= CW'(JOINT_SLOTS);
   assign rebind   = cmd.pt_commit && prior_ok;
   assign ovf      = cmd.pt_commit && !prior_ok && full;
   assign append   = cmd.pt_commit && !prior_ok && !full;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_REQ:   rd_addr = SW'(req_prior_slot[SLOT_FIELD_W-1:0]);
         RD_PRIOR: rd_addr = prior_idx;
         RD_LAST:  rd_addr = last_idx;
         RD_SCAN:  rd_addr = scan_idx;
         default:  rd_addr = scan_idx;
      endcase
   end

   // a move copies the last entry (read in the previous cycle) into the gap
   assign body_we     = append || cmd.cmp_move;
   assign body_waddr  = cmd.cmp_move ? scan_idx : count_idx;
   assign body_wdata  = cmd.cmp_move ? body_rdata : {body_a_ff, body_b_ff};
   assign point_we    = rebind || append || cmd.cmp_move;
   assign point_waddr = cmd.cmp_move ? scan_idx : (rebind ? prior_idx : count_idx);
   assign point_wdata = cmd.cmp_move ? point_rdata : point_ff;

   cjt_ram #(.WIDTH(2 * IW), .DEPTH(JOINT_SLOTS)) u_body_ram (
      .clock   (clock),
      .wr_en   (body_we),
      .wr_addr (body_waddr),
      .wr_data (body_wdata),
      .rd_addr (rd_addr),
      .rd_data (body_rdata)
   );

   cjt_ram #(.WIDTH(IW), .DEPTH(JOINT_SLOTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (point_we),
      .wr_addr (point_waddr),
      .wr_data (point_wdata),
      .rd_addr (rd_addr),
      .rd_data (point_rdata)
   );

   always_comb begin
      count_in = count_ff;
      scan_in  = scan_ff;
      bound_in = bound_ff;

      if (rebind) begin
         bound_in[prior_idx] = 1'b1;
      end
      if (append) begin
         bound_in[count_idx] = 1'b1;
         count_in            = count_ff + CW'(1);
      end
      if (cmd.cmp_skip || cmd.emit_load) begin
         scan_in = scan_ff + CW'(1);
      end
      if (cmd.cmp_move) begin
         bound_in[scan_idx] = bound_ff[last_idx];
         count_in           = count_ff - CW'(1);
      end
      if (cmd.scan_clear) begin
         scan_in = '0;
      end
      if (cmd.close_load) begin
         bound_in = '0;
      end
   end

   always_comb begin
      kind_in     = kind_ff;
      slot_in     = slot_ff;
      pref_in     = pref_ff;
      oba_in      = oba_ff;
      obb_in      = obb_ff;
      created_in  = created_ff;
      overflow_in = overflow_ff;
      live_in     = live_ff;
      last_in     = last_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (cmd.pt_commit) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_ACK;
         pref_in      = FIELD_W'(point_ff);
         created_in   = append;
         overflow_in  = ovf;
         live_in      = SLOT_FIELD_W'(append ? count_ff + CW'(1) : count_ff);
         last_in      = 1'b1;
         if (rebind) begin
            slot_in = prior_ff[SLOT_FIELD_W-1:0];
            oba_in  = FIELD_W'(body_rdata[2*IW-1:IW]);
            obb_in  = FIELD_W'(body_rdata[IW-1:0]);
         end else if (ovf) begin
            slot_in = '0;
            oba_in  = FIELD_W'(body_a_ff);
            obb_in  = FIELD_W'(body_b_ff);
         end else begin
            slot_in = SLOT_FIELD_W'(count_ff);
            oba_in  = FIELD_W'(body_a_ff);
            obb_in  = FIELD_W'(body_b_ff);
         end
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_SURV;
         slot_in      = SLOT_FIELD_W'(scan_ff);
         pref_in      = FIELD_W'(point_rdata);
         oba_in       = FIELD_W'(body_rdata[2*IW-1:IW]);
         obb_in       = FIELD_W'(body_rdata[IW-1:0]);
         created_in   = 1'b0;
         overflow_in  = 1'b0;
         live_in      = SLOT_FIELD_W'(count_ff);
         last_in      = 1'b0;
      end
      if (cmd.close_load) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_CLOSE;
         slot_in      = '0;
         pref_in      = '0;
         oba_in       = '0;
         obb_in       = '0;
         created_in   = 1'b0;
         overflow_in  = 1'b0;
         live_in      = SLOT_FIELD_W'(count_ff);
         last_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         bound_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         bound_ff     <= bound_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         point_ff  <= IW'(req_point_index);
         body_a_ff <= IW'(req_body_a);
         body_b_ff <= IW'(req_body_b);
         prior_ff  <= req_prior_slot;
      end
      kind_ff     <= kind_in;
      slot_ff     <= slot_in;
      pref_ff     <= pref_in;
      oba_ff      <= oba_in;
      obb_ff      <= obb_in;
      created_ff  <= created_in;
      overflow_ff <= overflow_in;
      live_ff     <= live_in;
      last_ff     <= last_in;
   end

   assign status.req_mode   = req_mode;
   assign status.out_free   = out_free;
   assign status.scan_done  = scan_ff >= count_ff;
   assign status.scan_bound = bound_ff[scan_idx];

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_joint_slot       = slot_ff;
   assign rsp_point_ref        = pref_ff;
   assign rsp_joint_body_a_out = oba_ff;
   assign rsp_joint_body_b_out = obb_ff;
   assign rsp_created          = created_ff;
   assign rsp_overflow         = overflow_ff;
   assign rsp_live_count       = live_ff;
   assign rsp_last             = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cjt_ctrl.sv =====
// Controller: sequences point requests and the end-of-frame compaction.
`default_nettype none

module cjt_ctrl import cjt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_POINT    = 7'b0000010,
      ST_SCAN     = 7'b0000100,
      ST_MOVE     = 7'b0001000,
      ST_EMIT_RD  = 7'b0010000,
      ST_EMIT_OUT = 7'b0100000,
      ST_CLOSE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = RD_SCAN;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.rd_sel = RD_REQ;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_mode) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_POINT;
               end
            end
         end
         ST_POINT: begin
            cmd.rd_sel = RD_PRIOR;
            if (status.out_free) begin
               cmd.pt_commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.rd_sel = RD_LAST;
            if (status.scan_done) begin
               cmd.scan_clear = 1'b1;
               state_in       = ST_EMIT_RD;
            end else if (status.scan_bound) begin
               cmd.cmp_skip = 1'b1;
            end else begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            // last entry is on the read port now; the gap is checked again next
            cmd.rd_sel   = RD_LAST;
            cmd.cmp_move = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_EMIT_RD: begin
            state_in = status.scan_done ? ST_CLOSE : ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_CLOSE: begin
            if (status.out_free) begin
               cmd.close_load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_contact_joint_table_refresh.sv =====
// Self-checking testbench for the contact joint table refresh block.
`timescale 1ns / 100ps

module tb_contact_joint_table_refresh import cjt_pkg::*; ();

   localparam int SLOTS      = 32;
   localparam int ITEM_GOAL  = 480;
   localparam int QUIET_AT   = 420;
   localparam int HOLD_AT    = 120;
   localparam int LONG_HOLD  = 300;
   localparam int DRAIN_WAIT = 200;
   localparam int LIMIT      = 400000;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [FIELD_W-1:0]      point;
      logic [FIELD_W-1:0]      body_a;
      logic [FIELD_W-1:0]      body_b;
      logic                    created;
      logic                    overflow;
      logic [SLOT_FIELD_W-1:0] live;
      logic                    last;
   } joint_rsp_type;

   // Mirror of the joint table; predicts the responses of each request.
   class joint_table_tracker;
      logic [FIELD_W-1:0] slot_a [SLOTS];
      logic [FIELD_W-1:0] slot_b [SLOTS];
      logic [FIELD_W-1:0] slot_pt [SLOTS];
      bit                 slot_mark [SLOTS];
      int                 live_n;
      int                 high_water;
      joint_rsp_type      awaited [$];
      int unsigned        errors;

      function void push_joint(logic [KIND_W-1:0] kind, int slot, logic [FIELD_W-1:0] pt,
                               logic [FIELD_W-1:0] ba, logic [FIELD_W-1:0] bb,
                               logic cr, logic ov, logic last);
         joint_rsp_type r;
         r.kind     = kind;
         r.slot     = SLOT_FIELD_W'(slot);
         r.point    = pt;
         r.body_a   = ba;
         r.body_b   = bb;
         r.created  = cr;
         r.overflow = ov;
         r.live     = SLOT_FIELD_W'(live_n);
         r.last     = last;
         awaited = {awaited, r};
      endfunction

      function void record_request(logic mode, logic [FIELD_W-1:0] pt,
                                   logic [FIELD_W-1:0] ba, logic [FIELD_W-1:0] bb,
                                   logic signed [PRIOR_W-1:0] prior);
         int j;
         int l;
         if (!mode) begin
            if (!prior[PRIOR_W-1] && int'(prior[PRIOR_W-2:0]) < live_n) begin
               j = int'(prior[PRIOR_W-2:0]);
               slot_pt[j]   = pt;
               slot_mark[j] = 1'b1;
               push_joint(KIND_ACK, j, pt, slot_a[j], slot_b[j], 1'b0, 1'b0, 1'b1);
            end else if (live_n >= SLOTS) begin
               push_joint(KIND_ACK, 0, pt, ba, bb, 1'b0, 1'b1, 1'b1);
            end else begin
               j = live_n;
               slot_a[j]    = ba;
               slot_b[j]    = bb;
               slot_pt[j]   = pt;
               slot_mark[j] = 1'b1;
               live_n++;
               if (live_n > high_water) high_water = live_n;
               push_joint(KIND_ACK, j, pt, ba, bb, 1'b1, 1'b0, 1'b1);
            end
         end else begin
            // unbound joint: pull the last entry into the gap and look again
            j = 0;
            while (j < live_n) begin
               if (!slot_mark[j]) begin
                  l = live_n - 1;
                  slot_a[j]    = slot_a[l];
                  slot_b[j]    = slot_b[l];
                  slot_pt[j]   = slot_pt[l];
                  slot_mark[j] = slot_mark[l];
                  live_n       = l;
               end else begin
                  j++;
               end
            end
            for (j = 0; j < live_n; j++)
               push_joint(KIND_SURV, j, slot_pt[j], slot_a[j], slot_b[j], 1'b0, 1'b0, 1'b0);
            push_joint(KIND_CLOSE, 0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
            for (j = 0; j < SLOTS; j++) slot_mark[j] = 1'b0;
         end
      endfunction

      function void check_response(joint_rsp_type got);
         joint_rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: kind=%0d slot=%0d point=%h live=%0d",
                        got.kind, got.slot, got.point, got.live);
            return;
         end
         want = awaited.pop_front();
         if (got.kind !== want.kind || got.slot !== want.slot || got.point !== want.point ||
             got.body_a !== want.body_a || got.body_b !== want.body_b ||
             got.created !== want.created || got.overflow !== want.overflow ||
             got.live !== want.live || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp: kind=%0d slot=%0d point=%h a=%h b=%h cr=%0b ov=%0b live=%0d last=%0b",
                        want.kind, want.slot, want.point, want.body_a, want.body_b,
                        want.created, want.overflow, want.live, want.last);
               $display("         got: kind=%0d slot=%0d point=%h a=%h b=%h cr=%0b ov=%0b live=%0d last=%0b",
                        got.kind, got.slot, got.point, got.body_a, got.body_b,
                        got.created, got.overflow, got.live, got.last);
            end
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_mode;
   logic [FIELD_W-1:0]          req_point_index;
   logic [FIELD_W-1:0]          req_body_a;
   logic [FIELD_W-1:0]          req_body_b;
   logic signed [PRIOR_W-1:0]   req_prior_slot;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [KIND_W-1:0]           rsp_kind;
   logic [SLOT_FIELD_W-1:0]     rsp_joint_slot;
   logic [FIELD_W-1:0]          rsp_point_ref;
   logic [FIELD_W-1:0]          rsp_joint_body_a_out;
   logic [FIELD_W-1:0]          rsp_joint_body_b_out;
   logic                        rsp_created;
   logic                        rsp_overflow;
   logic [SLOT_FIELD_W-1:0]     rsp_live_count;
   logic                        rsp_last;

   joint_table_tracker sb;
   joint_rsp_type      seen;
   int                 issued;
   int                 cycle_count;
   bit                 quiet;
   bit                 hold_pending;
   bit                 hold_done;

   contact_joint_table_refresh DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_point_index      (req_point_index),
      .req_body_a           (req_body_a),
      .req_body_b           (req_body_b),
      .req_prior_slot       (req_prior_slot),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_joint_slot       (rsp_joint_slot),
      .rsp_point_ref        (rsp_point_ref),
      .rsp_joint_body_a_out (rsp_joint_body_a_out),
      .rsp_joint_body_b_out (rsp_joint_body_b_out),
      .rsp_created          (rsp_created),
      .rsp_overflow         (rsp_overflow),
      .rsp_live_count       (rsp_live_count),
      .rsp_last             (rsp_last)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.kind     = rsp_kind;
         seen.slot     = rsp_joint_slot;
         seen.point    = rsp_point_ref;
         seen.body_a   = rsp_joint_body_a_out;
         seen.body_b   = rsp_joint_body_b_out;
         seen.created  = rsp_created;
         seen.overflow = rsp_overflow;
         seen.live     = rsp_live_count;
         seen.last     = rsp_last;
         sb.check_response(seen);
      end
   end

   // response side back-pressure; one long hold so the block backs up
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_pending = 1'b0;
         end
         if (!quiet && $urandom_range(0, 99) < 20) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end
      end
   end

   function automatic logic [FIELD_W-1:0] pick_index();
      case ($urandom_range(0, 9))
         0: pick_index = '0;
         1: pick_index = '1;
         default: pick_index = FIELD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Off-pattern prior slot: new, a live slot, or a stale slot at or above the live count.
   // Stale slots stay below the high-water mark (up to 63 once full), so no unwritten entry is read.
   function automatic logic signed [PRIOR_W-1:0] pick_prior();
      int hi;
      hi = (sb.high_water >= SLOTS) ? 63 : sb.high_water - 1;
      case ($urandom_range(0, 2))
         1: pick_prior = (sb.live_n > 0) ? PRIOR_W'($urandom_range(0, sb.live_n - 1)) : '1;
         2: pick_prior = (hi >= sb.live_n) ? PRIOR_W'($urandom_range(sb.live_n, hi)) : '1;
         default: pick_prior = '1;
      endcase
   endfunction

   task automatic send_request(input logic mode, input logic [FIELD_W-1:0] pt,
                               input logic [FIELD_W-1:0] ba, input logic [FIELD_W-1:0] bb,
                               input logic signed [PRIOR_W-1:0] prior);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_mode        = mode;
      req_point_index = pt;
      req_body_a      = ba;
      req_body_b      = bb;
      req_prior_slot  = prior;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.record_request(mode, pt, ba, bb, prior);
      issued++;
      if (issued >= HOLD_AT && !hold_done) begin
         hold_pending = 1'b1;
         hold_done    = 1'b1;
      end
      if (issued >= QUIET_AT) quiet = 1'b1;
   endtask

   // One frame: rebind some of last frame's joints, add new points, then compact.
   task automatic run_frame();
      int ops [$];
      int base;
      int keep_pct;
      int fresh;
      int k;
      int j;
      int tmp;
      base = sb.live_n;
      if ($urandom_range(0, 5) == 0) begin
         keep_pct = 100;
         fresh    = $urandom_range(20, 40);
      end else begin
         keep_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(0, 100);
         fresh    = $urandom_range(0, 10);
      end
      for (k = 0; k < base; k++) begin
         if ($urandom_range(0, 99) < keep_pct) begin
            ops = {ops, k};
            if ($urandom_range(0, 99) < 8) ops = {ops, k};
         end
      end
      for (k = 0; k < fresh; k++) ops = {ops, -1};
      for (k = ops.size() - 1; k > 0; k--) begin
         j      = $urandom_range(0, k);
         tmp    = ops[k];
         ops[k] = ops[j];
         ops[j] = tmp;
      end
      for (k = 0; k < ops.size(); k++) begin
         if ($urandom_range(0, 99) < 10)
            send_request(1'b0, pick_index(), pick_index(), pick_index(), pick_prior());
         else
            send_request(1'b0, pick_index(), pick_index(), pick_index(), PRIOR_W'(ops[k]));
      end
      send_request(1'b1, pick_index(), pick_index(), pick_index(), pick_prior());
   endtask

   initial begin
      sb              = new;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = 1'b0;
      req_point_index = '0;
      req_body_a      = '0;
      req_body_b      = '0;
      req_prior_slot  = '1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty compaction, field extremes, rebind, double bind,
      // removal by moving the last entry, stale slots treated as new
      send_request(1'b1, 16'h0000, 16'h0000, 16'h0000, '1);
      send_request(1'b0, 16'h0000, 16'h0000, 16'h0000, '1);
      send_request(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
      send_request(1'b0, 16'hAAAA, 16'h5555, 16'h0F0F, '1);
      send_request(1'b0, 16'h1234, 16'h0000, 16'h0000, 7'sd1);
      send_request(1'b0, 16'h4321, 16'hFFFF, 16'hFFFF, 7'sd1);
      send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'sd0);
      send_request(1'b0, 16'h0042, 16'h0001, 16'h0002, 7'sd2);
      send_request(1'b1, 16'h0000, 16'h0000, 16'h0000, '1);
      send_request(1'b0, 16'h0100, 16'h0200, 16'h0300, 7'sd1);
      send_request(1'b0, 16'h0101, 16'h0201, 16'h0301, 7'sd2);
      send_request(1'b0, 16'h0102, 16'h0202, 16'h0302, 7'sd0);
      send_request(1'b1, 16'h0000, 16'h0000, 16'h0000, '1);
      send_request(1'b1, 16'h0000, 16'h0000, 16'h0000, '1);
      send_request(1'b0, 16'h8001, 16'h7FFE, 16'hC003, 7'sd0);
      send_request(1'b1, 16'h0000, 16'h0000, 16'h0000, '1);

      while (issued < ITEM_GOAL) run_frame();

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/cjt_pkg.sv
rtl/core/cjt_ram.sv
rtl/core/cjt_dpath.sv
rtl/core/cjt_ctrl.sv
rtl/core/contact_joint_table_refresh.sv
dv/tb_contact_joint_table_refresh.sv
